// ----- rtl/gpm_pkg.sv -----
// Shared types, character codes and set helpers for the glob pattern matcher.
`timescale 1ns / 1ps

package gpm_pkg;

  // Default store sizes
  localparam int unsigned PATTERN_MAX = 64;
  localparam int unsigned NAME_MAX    = 256;

  // One bit per possible byte value in an element's match set
  localparam int unsigned SET_W = 256;

  // Action codes
  localparam logic [1:0] ACT_PAT  = 2'd0;
  localparam logic [1:0] ACT_NAME = 2'd1;
  localparam logic [1:0] ACT_EVAL = 2'd2;

  // Pattern syntax characters
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_Z   = 8'h7A;
  localparam logic [7:0] CASE_OFS  = 8'h20;

  // Top-level sequencer
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PARSE,
    ST_RUN
  } state_e;

  // Pattern parser position
  typedef enum logic [2:0] {
    CS_NORMAL,
    CS_FIRST,
    CS_BODY,
    CS_SKIP2,
    CS_SKIP1
  } cls_e;

  // Control pulses broadcast to every cell
  typedef struct packed {
    logic clr;
    logic init;
    logic step;
  } cell_ctl_t;

  // One compiled pattern element
  typedef struct packed {
    logic [SET_W-1:0] set;
    logic             valid;
    logic             star;
    logic             is_end;
  } cell_wr_t;

  // Byte set of one literal, with the other letter case when folding
  function automatic logic [SET_W-1:0] fold_set(logic [7:0] b, logic cf);
    logic [SET_W-1:0] s;
    s    = '0;
    s[b] = 1'b1;
    if (cf && b >= CH_UP_A && b <= CH_UP_Z) s[b + CASE_OFS] = 1'b1;
    if (cf && b >= CH_LO_A && b <= CH_LO_Z) s[b - CASE_OFS] = 1'b1;
    return s;
  endfunction

  // Byte set of an unfolded range lo..hi, empty when reversed
  function automatic logic [SET_W-1:0] range_set(logic [7:0] lo, logic [7:0] hi);
    logic [SET_W-1:0] s;
    for (int i = 0; i < SET_W; i++) begin
      s[i] = (8'(i) >= lo) && (8'(i) <= hi);
    end
    return s;
  endfunction

endpackage

// ----- rtl/gpm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module gpm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/gpm_cell.sv -----
// One NFA cell: holds one compiled pattern element and its active bit.
`timescale 1ns / 1ps

module gpm_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  gpm_pkg::cell_ctl_t ctl_i,
  input  logic [7:0]         byte_i,
  input  logic               head_i,
  input  logic               wr_i,
  input  gpm_pkg::cell_wr_t  wr_data_i,
  input  logic               carry_i,
  output logic               carry_o,
  output logic               accept_o
);

  logic [gpm_pkg::SET_W-1:0] set_q;
  logic                      valid_q;
  logic                      star_q;
  logic                      end_q;
  logic                      act_q;

  // Element flags and active bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      star_q  <= 1'b0;
      end_q   <= 1'b0;
      act_q   <= 1'b0;
    end else begin
      if (ctl_i.clr) begin
        valid_q <= 1'b0;
        end_q   <= 1'b0;
      end
      if (wr_i) begin
        valid_q <= wr_data_i.valid;
        star_q  <= wr_data_i.star;
        end_q   <= wr_data_i.is_end;
      end
      // a leading star lets the element stay active on any byte
      if (ctl_i.init) begin
        act_q <= head_i;
      end else if (ctl_i.step) begin
        act_q <= carry_i | (act_q & star_q);
      end
    end
  end

  // Match set
  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      set_q <= wr_data_i.set;
    end
  end

  // Hand activity to the next element when this one consumes the byte
  assign carry_o  = act_q & valid_q & set_q[byte_i];
  assign accept_o = act_q & end_q;

endmodule

// ----- rtl/glob_pattern_matcher.sv -----
// Glob matcher top level: stores, pattern compiler and NFA cell row.
// Pattern and name bytes are taken while idle, busy stays low.
// Evaluate: busy while the pattern compiles and the name runs; done pulses as
// busy falls. Compile walks the pattern RAM one byte a cycle, then the cell
// row consumes one name byte a cycle from the name RAM. One result per evaluate.
// Reset (async, low) clears lengths, flags and case_fold; results cannot stall.
`timescale 1ns / 1ps

module glob_pattern_matcher #(
  parameter int unsigned PATTERN_MAX = gpm_pkg::PATTERN_MAX,
  parameter int unsigned NAME_MAX    = gpm_pkg::NAME_MAX
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  logic [1:0] action_i,
  input  logic [7:0] data_byte_i,
  input  logic       first_i,
  output logic       done_o,
  output logic       matched_o,
  output logic       too_long_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_data_i
);

  localparam int unsigned PAW = $clog2(PATTERN_MAX);
  localparam int unsigned PLW = $clog2(PATTERN_MAX + 1);
  localparam int unsigned NAW = $clog2(NAME_MAX);
  localparam int unsigned NLW = $clog2(NAME_MAX + 1);
  localparam int unsigned CW  = $clog2(PATTERN_MAX + 4);
  localparam int unsigned RW  = $clog2(NAME_MAX + 2);
  localparam int unsigned NC  = PATTERN_MAX + 1;

  gpm_pkg::state_e state_q, state_d;
  gpm_pkg::cls_e   cls_q, cls_d;

  logic           case_fold_q;
  logic [PLW-1:0] pat_len_q, pat_len_d;
  logic           pat_over_q, pat_over_d;
  logic           close_vld_q, close_vld_d;
  logic [PAW-1:0] close_idx_q, close_idx_d;
  logic [NLW-1:0] name_len_q, name_len_d;
  logic           name_over_q, name_over_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic [RW-1:0]  rc_q, rc_d;
  logic [PLW-1:0] k_q, k_d;
  logic           star_pend_q, star_pend_d;
  logic           cur_neg_q, cur_neg_d;
  logic [gpm_pkg::SET_W-1:0] cur_set_q, cur_set_d;
  logic [7:0]     w_a_q, w_b_q;
  logic           done_q, done_d;
  logic           matched_q, matched_d;
  logic           too_long_q, too_long_d;

  logic           acc_in;
  logic [PLW-1:0] eff_len;
  logic           pat_we;
  logic           name_we;
  logic [7:0]     pat_rdata;
  logic [7:0]     name_rdata;
  logic [CW-1:0]  pl_ext;
  logic [CW-1:0]  pos_j;
  logic [RW-1:0]  nl_ext;
  logic           do_body;

  gpm_pkg::cell_ctl_t ctl;
  gpm_pkg::cell_wr_t  wr_data;
  logic               wr_en;
  logic [NC-1:0]      carry;
  logic [NC-1:0]      acc_vec;

  assign acc_in      = start_i & ~busy_o;
  assign busy_o      = (state_q != gpm_pkg::ST_IDLE);
  assign cfg_ready_o = 1'b1;

  // Store write ports
  assign eff_len = first_i ? '0 : pat_len_q;
  assign pat_we  = acc_in && (action_i == gpm_pkg::ACT_PAT)
                   && (eff_len < PLW'(PATTERN_MAX));
  assign name_we = acc_in && (action_i == gpm_pkg::ACT_NAME)
                   && (name_len_q < NLW'(NAME_MAX));

  gpm_ram #(
    .WIDTH (8),
    .DEPTH (PATTERN_MAX)
  ) u_pat_ram (
    .clk_i   (clk_i),
    .we_i    (pat_we),
    .waddr_i (eff_len[PAW-1:0]),
    .wdata_i (data_byte_i),
    .raddr_i (cnt_q[PAW-1:0]),
    .rdata_o (pat_rdata)
  );

  gpm_ram #(
    .WIDTH (8),
    .DEPTH (NAME_MAX)
  ) u_name_ram (
    .clk_i   (clk_i),
    .we_i    (name_we),
    .waddr_i (name_len_q[NAW-1:0]),
    .wdata_i (data_byte_i),
    .raddr_i (rc_q[NAW-1:0]),
    .rdata_o (name_rdata)
  );

  assign pl_ext  = CW'(pat_len_q);
  assign pos_j   = cnt_q - CW'(3);
  assign nl_ext  = RW'(name_len_q);
  assign do_body = (cls_q == gpm_pkg::CS_BODY)
                   || ((cls_q == gpm_pkg::CS_FIRST) && (w_b_q != gpm_pkg::CH_BANG));

  // Sequencer, pattern compiler and store bookkeeping
  always_comb begin
    state_d     = state_q;
    cls_d       = cls_q;
    pat_len_d   = pat_len_q;
    pat_over_d  = pat_over_q;
    close_vld_d = close_vld_q;
    close_idx_d = close_idx_q;
    name_len_d  = name_len_q;
    name_over_d = name_over_q;
    cnt_d       = cnt_q;
    rc_d        = rc_q;
    k_d         = k_q;
    star_pend_d = star_pend_q;
    cur_neg_d   = cur_neg_q;
    cur_set_d   = cur_set_q;
    done_d      = 1'b0;
    matched_d   = matched_q;
    too_long_d  = too_long_q;
    ctl         = '0;
    wr_en       = 1'b0;
    wr_data     = '0;

    case (state_q)
      gpm_pkg::ST_IDLE: begin
        if (acc_in) begin
          case (action_i)
            gpm_pkg::ACT_PAT: begin
              if (first_i) begin
                pat_over_d  = 1'b0;
                close_vld_d = 1'b0;
              end
              if (pat_we) begin
                pat_len_d = eff_len + PLW'(1);
                if (data_byte_i == gpm_pkg::CH_RBRACK) begin
                  close_vld_d = 1'b1;
                  close_idx_d = eff_len[PAW-1:0];
                end
              end else begin
                pat_over_d = 1'b1;
              end
            end
            gpm_pkg::ACT_NAME: begin
              if (name_we) begin
                name_len_d = name_len_q + NLW'(1);
              end else begin
                name_over_d = 1'b1;
              end
            end
            gpm_pkg::ACT_EVAL: begin
              ctl.clr     = 1'b1;
              state_d     = gpm_pkg::ST_PARSE;
              cls_d       = gpm_pkg::CS_NORMAL;
              cnt_d       = '0;
              k_d         = '0;
              star_pend_d = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end

      gpm_pkg::ST_PARSE: begin
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == pl_ext + CW'(3)) begin
          // closing end-of-pattern cell
          wr_en          = 1'b1;
          wr_data.is_end = 1'b1;
          wr_data.star   = star_pend_q;
          ctl.init       = 1'b1;
          state_d        = gpm_pkg::ST_RUN;
          rc_d           = '0;
        end else if (cnt_q >= CW'(3)) begin
          // w_b_q is byte j, w_a_q byte j+1, pat_rdata byte j+2
          case (cls_q)
            gpm_pkg::CS_NORMAL: begin
              if (w_b_q == gpm_pkg::CH_STAR) begin
                star_pend_d = 1'b1;
              end else if ((w_b_q == gpm_pkg::CH_LBRACK) && close_vld_q
                           && (CW'(close_idx_q) > pos_j)) begin
                cls_d     = gpm_pkg::CS_FIRST;
                cur_set_d = '0;
                cur_neg_d = 1'b0;
              end else begin
                wr_en         = 1'b1;
                wr_data.valid = 1'b1;
                wr_data.star  = star_pend_q;
                wr_data.set   = (w_b_q == gpm_pkg::CH_QMARK) ? '1
                                : gpm_pkg::fold_set(w_b_q, case_fold_q);
                star_pend_d   = 1'b0;
              end
            end
            gpm_pkg::CS_SKIP2: cls_d = gpm_pkg::CS_SKIP1;
            gpm_pkg::CS_SKIP1: cls_d = gpm_pkg::CS_BODY;
            default: begin
              if (!do_body) begin
                // leading bang negates the class
                cur_neg_d = 1'b1;
                cls_d     = gpm_pkg::CS_BODY;
              end else if (w_b_q == gpm_pkg::CH_RBRACK) begin
                wr_en         = 1'b1;
                wr_data.valid = 1'b1;
                wr_data.star  = star_pend_q;
                wr_data.set   = cur_neg_q ? ~cur_set_q : cur_set_q;
                star_pend_d   = 1'b0;
                cls_d         = gpm_pkg::CS_NORMAL;
              end else if ((w_a_q == gpm_pkg::CH_DASH)
                           && (pat_rdata != gpm_pkg::CH_RBRACK)) begin
                cur_set_d = cur_set_q | gpm_pkg::range_set(w_b_q, pat_rdata);
                cls_d     = gpm_pkg::CS_SKIP2;
              end else begin
                cur_set_d = cur_set_q | gpm_pkg::fold_set(w_b_q, case_fold_q);
                cls_d     = gpm_pkg::CS_BODY;
              end
            end
          endcase
        end
        if (wr_en) begin
          k_d = k_q + PLW'(1);
        end
      end

      gpm_pkg::ST_RUN: begin
        rc_d = rc_q + RW'(1);
        if (rc_q == nl_ext + RW'(1)) begin
          done_d      = 1'b1;
          too_long_d  = pat_over_q | name_over_q;
          matched_d   = ~(pat_over_q | name_over_q) & (|acc_vec);
          name_len_d  = '0;
          name_over_d = 1'b0;
          state_d     = gpm_pkg::ST_IDLE;
        end else if (rc_q != '0) begin
          ctl.step = 1'b1;
        end
      end

      default: state_d = gpm_pkg::ST_IDLE;
    endcase
  end

  // State register and control flops
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gpm_pkg::ST_IDLE;
      cls_q       <= gpm_pkg::CS_NORMAL;
      case_fold_q <= 1'b0;
      pat_len_q   <= '0;
      pat_over_q  <= 1'b0;
      close_vld_q <= 1'b0;
      close_idx_q <= '0;
      name_len_q  <= '0;
      name_over_q <= 1'b0;
      cnt_q       <= '0;
      rc_q        <= '0;
      k_q         <= '0;
      star_pend_q <= 1'b0;
      cur_neg_q   <= 1'b0;
      done_q      <= 1'b0;
      matched_q   <= 1'b0;
      too_long_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      cls_q       <= cls_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case_fold_q <= cfg_data_i;
      end
      pat_len_q   <= pat_len_d;
      pat_over_q  <= pat_over_d;
      close_vld_q <= close_vld_d;
      close_idx_q <= close_idx_d;
      name_len_q  <= name_len_d;
      name_over_q <= name_over_d;
      cnt_q       <= cnt_d;
      rc_q        <= rc_d;
      k_q         <= k_d;
      star_pend_q <= star_pend_d;
      cur_neg_q   <= cur_neg_d;
      done_q      <= done_d;
      matched_q   <= matched_d;
      too_long_q  <= too_long_d;
    end
  end

  // Class set accumulator and pattern byte window
  always_ff @(posedge clk_i) begin
    cur_set_q <= cur_set_d;
    w_a_q     <= pat_rdata;
    w_b_q     <= w_a_q;
  end

  // Row of NFA cells
  for (genvar i = 0; i < NC; i++) begin : g_cell
    logic carry_in;
    if (i == 0) begin : g_head
      assign carry_in = 1'b0;
    end else begin : g_link
      assign carry_in = carry[i-1];
    end

    gpm_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctl_i     (ctl),
      .byte_i    (name_rdata),
      .head_i    ((i == 0) ? 1'b1 : 1'b0),
      .wr_i      (wr_en && (k_q == PLW'(i))),
      .wr_data_i (wr_data),
      .carry_i   (carry_in),
      .carry_o   (carry[i]),
      .accept_o  (acc_vec[i])
    );
  end

  assign done_o     = done_q;
  assign matched_o  = matched_q;
  assign too_long_o = too_long_q;

endmodule
